[rtl/core/mamt_pkg.sv]
// Shared constants for the masked address match table.
package mamt_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int HALF_W      = 64;
    localparam int WORD_W      = 4 * HALF_W;
    localparam int COUNT_OUT_W = 7;

    // Operation codes on the request
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    // IPv4 compares only the top 32 bits of the high half
    localparam logic [HALF_W-1:0] V4_BITS = 64'hFFFF_FFFF_0000_0000;

endpackage

[rtl/core/mamt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mamt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/mamt_ctrl.sv]
// Request sequencer: appends entries, scans the table one entry per cycle, compares.
module mamt_ctrl #(
    parameter int ENTRIES = mamt_pkg::ENTRIES_DEF,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [mamt_pkg::HALF_W-1:0]       addr_hi,
    input  logic [mamt_pkg::HALF_W-1:0]       addr_lo,
    input  logic [mamt_pkg::HALF_W-1:0]       mask_hi,
    input  logic [mamt_pkg::HALF_W-1:0]       mask_lo,
    input  logic                              is_ipv6,
    output logic                              done,
    output logic                              matched,
    output logic                              table_full,
    output logic [mamt_pkg::COUNT_OUT_W-1:0]  entry_count,
    output logic                              ram_we,
    output logic [IDX_W-1:0]                  ram_waddr,
    output logic [mamt_pkg::WORD_W-1:0]       ram_wdata,
    output logic                              ram_re,
    output logic [IDX_W-1:0]                  ram_raddr,
    input  logic [mamt_pkg::WORD_W-1:0]       ram_rdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam int H = mamt_pkg::HALF_W;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             done_reg, done_next;
    logic             matched_reg, matched_next;
    logic             full_reg, full_next;
    logic [H-1:0]     src_hi_reg, src_lo_reg;
    logic             v6_reg;

    logic             accept;
    logic             is_full;
    logic             last_issue;
    logic             hit;
    logic [H-1:0]     e_addr_hi, e_addr_lo, e_mask_hi, e_mask_lo, m_hi;
    logic [CNT_W+mamt_pkg::COUNT_OUT_W-1:0] count_ext;

    assign accept     = start && !busy;
    assign is_full    = (count_reg == CNT_W'(ENTRIES));
    assign last_issue = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign e_addr_hi = ram_rdata[4*H-1:3*H];
    assign e_addr_lo = ram_rdata[3*H-1:2*H];
    assign e_mask_hi = ram_rdata[2*H-1:H];
    assign e_mask_lo = ram_rdata[H-1:0];
    assign m_hi      = v6_reg ? e_mask_hi : (e_mask_hi & mamt_pkg::V4_BITS);

    always_comb
    begin
        hit = ((e_addr_hi & m_hi) == (src_hi_reg & m_hi));
        if (v6_reg)
        begin
            hit = hit && ((e_addr_lo & e_mask_lo) == (src_lo_reg & e_mask_lo));
        end
    end

    // Appends go straight to the next free slot
    assign ram_we    = accept && (operation == mamt_pkg::OP_ADD) && !is_full;
    assign ram_waddr = count_reg[IDX_W-1:0];
    assign ram_wdata = {addr_hi, addr_lo, mask_hi, mask_lo};
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_raddr = idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_vld_next  = 1'b0;
        done_next    = 1'b0;
        matched_next = 1'b0;
        full_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == mamt_pkg::OP_ADD)
                    begin
                        done_next = 1'b1;
                        if (is_full)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_vld_reg && hit)
                begin
                    // stop early; drop the read issued this cycle
                    done_next    = 1'b1;
                    matched_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    rd_vld_next = 1'b1;
                    idx_next    = idx_reg + IDX_W'(1);
                    if (last_issue)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                done_next    = 1'b1;
                matched_next = rd_vld_reg && hit;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            matched_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            done_reg    <= done_next;
            matched_reg <= matched_next;
            full_reg    <= full_next;
        end
    end

    // Hold the match source for the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_hi_reg <= addr_hi;
            src_lo_reg <= addr_lo;
            v6_reg     <= is_ipv6;
        end
    end

    assign count_ext   = {{mamt_pkg::COUNT_OUT_W{1'b0}}, count_reg};
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign matched     = matched_reg;
    assign table_full  = full_reg;
    assign entry_count = count_ext[mamt_pkg::COUNT_OUT_W-1:0];

endmodule

[rtl/core/masked_address_match_table.sv]
// Top level of the masked address match table: sequencer and entry RAM.
//
//   channel   signals                                        direction
//   request   start, busy, operation, addr_hi/lo,            in (busy out)
//             mask_hi/lo, is_ipv6
//   result    done, matched, table_full, entry_count         out
//
// An add answers in the cycle after it is taken and leaves busy low.
// A match reads the entry RAM one entry per cycle through its single read
// port and stops early on a hit; busy stays high meanwhile. A match on an
// empty table answers like an add and leaves busy low.
// Reset clears the entry count and the sequencer state; RAM contents are not cleared.
// done is high for exactly one cycle per request; the receiver cannot stall.
module masked_address_match_table #(
    parameter int ENTRIES = mamt_pkg::ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [mamt_pkg::HALF_W-1:0]       addr_hi,
    input  logic [mamt_pkg::HALF_W-1:0]       addr_lo,
    input  logic [mamt_pkg::HALF_W-1:0]       mask_hi,
    input  logic [mamt_pkg::HALF_W-1:0]       mask_lo,
    input  logic                              is_ipv6,
    output logic                              done,
    output logic                              matched,
    output logic                              table_full,
    output logic [mamt_pkg::COUNT_OUT_W-1:0]  entry_count
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [mamt_pkg::WORD_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [IDX_W-1:0]              ram_raddr;
    logic [mamt_pkg::WORD_W-1:0]   ram_rdata;

    mamt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .addr_hi     (addr_hi),
        .addr_lo     (addr_lo),
        .mask_hi     (mask_hi),
        .mask_lo     (mask_lo),
        .is_ipv6     (is_ipv6),
        .done        (done),
        .matched     (matched),
        .table_full  (table_full),
        .entry_count (entry_count),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    mamt_ram #(
        .WIDTH (mamt_pkg::WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[tb/match_table_monitor.sv]
`timescale 1ns / 100ps
// Predicts and checks every answer of the masked address match table.
module match_table_monitor #(
    parameter int ENTRIES = mamt_pkg::ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              operation,
    input  logic [mamt_pkg::HALF_W-1:0]       addr_hi,
    input  logic [mamt_pkg::HALF_W-1:0]       addr_lo,
    input  logic [mamt_pkg::HALF_W-1:0]       mask_hi,
    input  logic [mamt_pkg::HALF_W-1:0]       mask_lo,
    input  logic                              is_ipv6,
    input  logic                              done,
    input  logic                              matched,
    input  logic                              table_full,
    input  logic [mamt_pkg::COUNT_OUT_W-1:0]  entry_count,
    output int                                mismatches,
    output int                                pending,
    output int                                answered,
    output int                                hits,
    output int                                drops
);
    import mamt_pkg::*;

    typedef struct packed {
        logic                   matched;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] entry_count;
    } answer_t;

    logic [HALF_W-1:0] tab_addr_hi [ENTRIES];
    logic [HALF_W-1:0] tab_addr_lo [ENTRIES];
    logic [HALF_W-1:0] tab_mask_hi [ENTRIES];
    logic [HALF_W-1:0] tab_mask_lo [ENTRIES];
    int unsigned       used;
    answer_t           answer_q [$];

    task automatic report(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    // Store or look up one request against the shadow table.
    function automatic answer_t apply_request(
        input logic              op,
        input logic [HALF_W-1:0] a_hi,
        input logic [HALF_W-1:0] a_lo,
        input logic [HALF_W-1:0] m_hi,
        input logic [HALF_W-1:0] m_lo,
        input logic              v6
    );
        answer_t           ans;
        logic [HALF_W-1:0] cmp_hi;
        ans = '0;
        if (op == OP_ADD)
        begin
            if (used >= ENTRIES)
            begin
                ans.table_full = 1'b1;
            end
            else
            begin
                tab_addr_hi[used] = a_hi;
                tab_addr_lo[used] = a_lo;
                tab_mask_hi[used] = m_hi;
                tab_mask_lo[used] = m_lo;
                used++;
            end
        end
        else
        begin
            for (int k = 0; k < used && !ans.matched; k++)
            begin
                // IPv4 looks only at the top 32 address bits
                cmp_hi = v6 ? tab_mask_hi[k] : (tab_mask_hi[k] & V4_BITS);
                if ((((tab_addr_hi[k] ^ a_hi) & cmp_hi) == '0) &&
                    (!v6 || (((tab_addr_lo[k] ^ a_lo) & tab_mask_lo[k]) == '0)))
                    ans.matched = 1'b1;
            end
        end
        ans.entry_count = used[COUNT_OUT_W-1:0];
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            used = 0;
            answer_q.delete();
        end
        else
        begin
            // Retire the answer first: it belongs to an older request.
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    report("answer with no request outstanding");
                end
                else
                begin
                    want = answer_q.pop_front();
                    answered++;
                    if (matched !== want.matched)
                        report($sformatf("matched got %b want %b",
                                         matched, want.matched));
                    if (table_full !== want.table_full)
                        report($sformatf("table_full got %b want %b",
                                         table_full, want.table_full));
                    if (entry_count !== want.entry_count)
                        report($sformatf("entry_count got %0d want %0d",
                                         entry_count, want.entry_count));
                    if (want.matched)
                        hits++;
                    if (want.table_full)
                        drops++;
                end
            end
            if (start && !busy)
                answer_q.push_back(apply_request(operation, addr_hi, addr_lo,
                                                 mask_hi, mask_lo, is_ipv6));
        end
        pending = answer_q.size();
    end

endmodule

[tb/masked_address_match_table_tb.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the masked address match table.
module masked_address_match_table_tb;
    import mamt_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int ADDR_W  = 2 * HALF_W;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   operation;
    logic [HALF_W-1:0]      addr_hi;
    logic [HALF_W-1:0]      addr_lo;
    logic [HALF_W-1:0]      mask_hi;
    logic [HALF_W-1:0]      mask_lo;
    logic                   is_ipv6;
    logic                   done;
    logic                   matched;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] entry_count;

    int mismatches;
    int pending;
    int answered;
    int hits;
    int drops;

    int                requests;
    int                burst_left;
    logic [ADDR_W-1:0] kept_addr [$];
    logic [ADDR_W-1:0] kept_mask [$];

    masked_address_match_table #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .addr_hi(addr_hi),
        .addr_lo(addr_lo),
        .mask_hi(mask_hi),
        .mask_lo(mask_lo),
        .is_ipv6(is_ipv6),
        .done(done),
        .matched(matched),
        .table_full(table_full),
        .entry_count(entry_count)
    );

    match_table_monitor #(
        .ENTRIES(ENTRIES)
    ) table_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .addr_hi(addr_hi),
        .addr_lo(addr_lo),
        .mask_hi(mask_hi),
        .mask_lo(mask_lo),
        .is_ipv6(is_ipv6),
        .done(done),
        .matched(matched),
        .table_full(table_full),
        .entry_count(entry_count),
        .mismatches(mismatches),
        .pending(pending),
        .answered(answered),
        .hits(hits),
        .drops(drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d answers still outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
        return {ADDR_W{1'b1}} << (ADDR_W - len);
    endfunction

    task automatic issue(
        input logic              op,
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] mask,
        input logic              v6
    );
        bit taken;
        // Drop start for a random gap between bursts.
        if (burst_left == 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(12, 0)) @(negedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 1);
        end
        burst_left--;
        @(negedge clk);
        start     = 1'b1;
        operation = op;
        addr_hi   = addr[ADDR_W-1:HALF_W];
        addr_lo   = addr[HALF_W-1:0];
        mask_hi   = mask[ADDR_W-1:HALF_W];
        mask_lo   = mask[HALF_W-1:0];
        is_ipv6   = v6;
        do
        begin
            @(posedge clk);
            taken = !busy;
        end
        while (!taken);
        requests++;
        if (op == OP_ADD && kept_addr.size() < ENTRIES)
        begin
            kept_addr.push_back(addr);
            kept_mask.push_back(mask);
        end
    endtask

    task automatic send_entry();
        logic [ADDR_W-1:0] m;
        // Keep some IPv4 bits in every mask so lookups are not all hits.
        if ($urandom_range(3, 0) == 0)
            m = rand128() | prefix_mask(8);
        else
            m = prefix_mask($urandom_range(ADDR_W, 24));
        issue(OP_ADD, rand128(), m, 1'($urandom_range(1, 0)));
    endtask

    task automatic send_probe();
        logic [ADDR_W-1:0] a;
        int                k;
        int                bit_pos;
        if (kept_addr.size() == 0 || $urandom_range(7, 0) == 0)
        begin
            a = rand128();
        end
        else
        begin
            // Aim at a stored entry, random outside its mask.
            k = $urandom_range(kept_addr.size() - 1, 0);
            a = (kept_addr[k] & kept_mask[k]) | (rand128() & ~kept_mask[k]);
            if ($urandom_range(2, 0) == 0)
            begin
                bit_pos = $urandom_range(1, 0) ? $urandom_range(ADDR_W - 1, ADDR_W - 32)
                                               : $urandom_range(ADDR_W - 1, 0);
                a[bit_pos] = ~a[bit_pos];
            end
        end
        issue(OP_MATCH, a, rand128(), 1'($urandom_range(1, 0)));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = OP_ADD;
        addr_hi    = '0;
        addr_lo    = '0;
        mask_hi    = '0;
        mask_lo    = '0;
        is_ipv6    = 1'b0;
        requests   = 0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Lookups on an empty table
        issue(OP_MATCH, '0, '0, 1'b0);
        issue(OP_MATCH, '1, '1, 1'b1);
        // All-ones entry, full compare
        issue(OP_ADD, '1, '1, 1'b0);
        issue(OP_MATCH, '1, '0, 1'b1);
        issue(OP_MATCH, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, '1, 1'b0);
        issue(OP_MATCH, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE}, '0, 1'b1);
        issue(OP_MATCH, {64'hFFFF_FFFE_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, '0, 1'b0);
        issue(OP_MATCH, {64'hFFFF_FFFF_0000_0000, 64'h0}, '0, 1'b0);
        // Zero address, mask only on the IPv4 bits; family ignored on add
        issue(OP_ADD, '0, {V4_BITS, 64'h0}, 1'b1);
        issue(OP_MATCH, {32'h0, $urandom, $urandom, $urandom}, '1, 1'b0);
        issue(OP_MATCH, {64'h0000_0000_FFFF_FFFF, $urandom, $urandom}, '0, 1'b1);
        // Distinct full-width entry
        issue(OP_ADD, {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}, '1, 1'b1);
        issue(OP_MATCH, {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}, '0, 1'b1);
        issue(OP_MATCH, {64'h0123_4567_89AB_CDEF, 64'h7EDC_BA98_7654_3210}, '0, 1'b1);
        issue(OP_MATCH, {64'h0123_4567_89AB_CDEF, 64'h0}, '0, 1'b0);

        // Fill all but the last slot, probing as entries accumulate
        while (kept_addr.size() < ENTRIES - 1)
        begin
            if ($urandom_range(2, 0) == 0)
                send_entry();
            else
                send_probe();
        end
        repeat (650) send_probe();

        // Catch-all last entry, then adds against a full table
        issue(OP_ADD, rand128(), '0, 1'b0);
        issue(OP_MATCH, '0, '1, 1'b0);
        issue(OP_MATCH, '1, '0, 1'b1);
        issue(OP_ADD, '1, '1, 1'b0);
        issue(OP_ADD, '0, '0, 1'b1);
        repeat (40)
        begin
            if ($urandom_range(1, 0))
                send_entry();
            else
                send_probe();
        end

        @(negedge clk);
        start = 1'b0;
        wait (pending == 0);
        repeat (ENTRIES + 16) @(posedge clk);

        $display("Sent %0d requests and checked %0d answers.", requests, answered);
        $display("Lookups hit %0d times; %0d adds were refused by a full table.",
                 hits, drops);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
